@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expects a signal named clk, and AST_CLKD also one named rst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held low
`define AST_CLKD(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed under reset gating");

// Clocked check that also holds while reset is low
`define AST_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed at clock edge");

`endif

@@ design/mcpwm_pkg.sv @@
// Shared types, constants and helpers for the multi-channel PWM generator.
// No dependencies; used by mcpwm_lane, the top level and the checker.
package mcpwm_pkg;

  localparam int CHANNELS_DEF      = 16;
  localparam int DEFAULT_PULSE_DEF = 20000;

  localparam int PIN_W       = 16;
  localparam int TIME_W      = 32;
  localparam int CH_W        = 5;
  localparam int OP_W        = 3;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 32;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_CONFIGURE = 3'd1;
  localparam logic [OP_W-1:0] OP_ENABLE    = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE   = 3'd3;
  localparam logic [OP_W-1:0] OP_MODIFY    = 3'd4;
  localparam logic [OP_W-1:0] OP_FORCE_HI  = 3'd5;
  localparam logic [OP_W-1:0] OP_FORCE_LO  = 3'd6;
  localparam logic [OP_W-1:0] OP_TEST      = 3'd7;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOWED   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE = 1'b1;

  // Broadcast to every lane; at most one of the write strobes is set
  typedef struct packed {
    logic              tick;
    logic              cfg_wr;
    logic              en_flag;
    logic              ena_wr;
    logic              dis_wr;
    logic              mod_wr;
    logic [CH_W-1:0]   ch;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] now_nxt;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
  } lane_cmd_t;

  // Lane status back to the top
  typedef struct packed {
    logic enabled;
    logic next_level;
    logic toggle;
  } lane_stat_t;

  // Zero-length times are stored as one tick
  function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] t);
    return (t == '0) ? TIME_W'(1) : t;
  endfunction

endpackage

@@ design/mcpwm_lane.sv @@
// One PWM channel: enable, level, deadline and high/low times.
// Depends on mcpwm_pkg.
module mcpwm_lane #(
  parameter int          IDX           = 0,
  parameter logic [31:0] DEFAULT_PULSE = 32'(mcpwm_pkg::DEFAULT_PULSE_DEF)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  mcpwm_pkg::lane_cmd_t   cmd,
  output mcpwm_pkg::lane_stat_t  stat
);
  import mcpwm_pkg::*;

  logic              enabled_r, enabled_nxt;
  logic              level_r, level_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic [TIME_W-1:0] high_r, high_nxt;
  logic [TIME_W-1:0] low_r, low_nxt;
  logic [TIME_W-1:0] slack;
  logic              hit;
  logic              toggle;

  assign hit = (cmd.ch == CH_W'(IDX));

  // Wrap-safe deadline check against the advanced time
  assign slack  = deadline_r - cmd.now_nxt;
  assign toggle = cmd.tick && enabled_r && slack[TIME_W-1];

  assign stat.enabled    = enabled_r;
  assign stat.next_level = !level_r;
  assign stat.toggle     = toggle;

  // Next state
  always_comb begin
    enabled_nxt  = enabled_r;
    level_nxt    = level_r;
    deadline_nxt = deadline_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    if (toggle) begin
      level_nxt    = !level_r;
      deadline_nxt = deadline_r + (level_r ? low_r : high_r);
    end
    if (hit) begin
      if (cmd.cfg_wr) begin
        level_nxt = 1'b0;
        if (cmd.en_flag) begin
          enabled_nxt  = 1'b1;
          deadline_nxt = cmd.now;
          high_nxt     = at_least_one(cmd.high_time);
          low_nxt      = at_least_one(cmd.low_time);
        end else begin
          enabled_nxt = 1'b0;
          high_nxt    = DEFAULT_PULSE;
          low_nxt     = DEFAULT_PULSE;
        end
      end
      if (cmd.ena_wr) begin
        enabled_nxt  = 1'b1;
        deadline_nxt = cmd.now;
      end
      if (cmd.dis_wr) begin
        enabled_nxt = 1'b0;
      end
      if (cmd.mod_wr) begin
        high_nxt = at_least_one(cmd.high_time);
        low_nxt  = at_least_one(cmd.low_time);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      level_r    <= 1'b0;
      deadline_r <= '0;
      high_r     <= DEFAULT_PULSE;
      low_r      <= DEFAULT_PULSE;
    end else if (fire) begin
      enabled_r  <= enabled_nxt;
      level_r    <= level_nxt;
      deadline_r <= deadline_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
    end
  end

endmodule

@@ design/multi_channel_pwm_generator.sv @@
// Top level of the multi-channel PWM generator.
// Depends on mcpwm_pkg and mcpwm_lane.
//
// Usage:
//   Input stream (in_*): one word per tick or command. in_tuser carries the
//   command code; in_tdata carries channel, high time, low time, enable flag.
//   Result stream (out_*): one word per input word, carrying the pin levels
//   after that word and an applied flag.
//   Config port (cfg_*): single-cycle writes of allowed-channel mask (index 0)
//   and minimum pulse (index 1); write only while no word is in flight.
// Timing:
//   A word lands in the input register, is evaluated across all channel
//   lanes combinationally, and its result is registered in the output register.
//   Throughput is one word per cycle while out_tready is high; every channel's
//   deadline compare and add run in parallel in its own lane.
// Reset (rst_n low, synchronous): all channels disabled, pins low, time
//   zero, deadlines zero, times at the default pulse, config at reset values.
// Stall: when out_tready is low the result holds; one more word is held in
//   the input register, after which in_tready drops.
module multi_channel_pwm_generator #(
  parameter int CHANNELS      = mcpwm_pkg::CHANNELS_DEF,
  parameter int DEFAULT_PULSE = mcpwm_pkg::DEFAULT_PULSE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // channel[4:0], high_time[36:5], low_time[68:37], enable_flag[69], zero pad
  input  logic [mcpwm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[2:0]
  input  logic [mcpwm_pkg::OP_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pins[15:0], applied[16], zero pad
  output logic [mcpwm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_we,
  input  logic [mcpwm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mcpwm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mcpwm_pkg::*;

  // Input register
  logic              in_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [CH_W-1:0]   ch_r;
  logic [TIME_W-1:0] hi_r;
  logic [TIME_W-1:0] lo_r;
  logic              en_flag_r;
  logic              fire;

  // Configuration and global state
  logic [PIN_W-1:0]  allowed_r;
  logic [TIME_W-1:0] min_pulse_r;
  logic [TIME_W-1:0] time_r;
  logic [PIN_W-1:0]  pins_r, pins_nxt;

  // Output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Decode
  logic is_tick, is_cfg, is_ena, is_dis, is_mod, is_fhi, is_flo, is_test;
  logic in_range, ch_allowed, ch_enabled;
  logic ena_ok, dis_ok, mod_ok, applied;
  logic [31:0] en32, allowed32;
  logic [CHANNELS-1:0] enabled_vec;

  lane_cmd_t  cmd;
  lane_stat_t stat [CHANNELS];

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r      <= in_tuser;
      ch_r      <= in_tdata[4:0];
      hi_r      <= in_tdata[36:5];
      lo_r      <= in_tdata[68:37];
      en_flag_r <= in_tdata[69];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_r   <= '1;
      min_pulse_r <= TIME_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALLOWED:   allowed_r   <= cfg_wdata[PIN_W-1:0];
        REG_MIN_PULSE: min_pulse_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode and checks
  assign is_tick = (op_r == OP_TICK);
  assign is_cfg  = (op_r == OP_CONFIGURE);
  assign is_ena  = (op_r == OP_ENABLE);
  assign is_dis  = (op_r == OP_DISABLE);
  assign is_mod  = (op_r == OP_MODIFY);
  assign is_fhi  = (op_r == OP_FORCE_HI);
  assign is_flo  = (op_r == OP_FORCE_LO);
  assign is_test = (op_r == OP_TEST);

  assign in_range   = ({1'b0, ch_r} < 6'(CHANNELS));
  assign en32       = 32'(enabled_vec);
  assign allowed32  = 32'(allowed_r);
  assign ch_allowed = in_range && allowed32[ch_r];
  assign ch_enabled = en32[ch_r];

  assign ena_ok = is_ena && ch_allowed && !ch_enabled;
  assign dis_ok = is_dis && ch_allowed && ch_enabled;
  assign mod_ok = is_mod && ch_allowed && (hi_r >= min_pulse_r) && (lo_r >= min_pulse_r);

  assign applied = is_tick || is_test || ena_ok || dis_ok || mod_ok ||
                   (in_range && (is_cfg || is_fhi || is_flo));

  // Lane command broadcast
  always_comb begin
    cmd.tick      = is_tick;
    cmd.cfg_wr    = is_cfg && in_range;
    cmd.en_flag   = en_flag_r;
    cmd.ena_wr    = ena_ok;
    cmd.dis_wr    = dis_ok;
    cmd.mod_wr    = mod_ok;
    cmd.ch        = ch_r;
    cmd.now       = time_r;
    cmd.now_nxt   = time_r + TIME_W'(1);
    cmd.high_time = hi_r;
    cmd.low_time  = lo_r;
  end

  // Time count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (fire && is_tick) begin
      time_r <= cmd.now_nxt;
    end
  end

  // Channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mcpwm_lane #(
      .IDX           (g),
      .DEFAULT_PULSE (32'(DEFAULT_PULSE))
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .fire  (fire),
      .cmd   (cmd),
      .stat  (stat[g])
    );
    assign enabled_vec[g] = stat[g].enabled;
  end

  // Pin levels; only the first PIN_W channels have a pin
  for (genvar p = 0; p < PIN_W; p++) begin : g_pin
    if (p < CHANNELS) begin : g_drv
      logic hit;
      assign hit = (ch_r == CH_W'(p));
      always_comb begin
        pins_nxt[p] = pins_r[p];
        if (is_tick) begin
          if (stat[p].toggle) begin
            pins_nxt[p] = stat[p].next_level;
          end
        end else if (hit && (ena_ok || is_fhi)) begin
          pins_nxt[p] = 1'b1;
        end else if (hit && (dis_ok || is_flo)) begin
          pins_nxt[p] = 1'b0;
        end
      end
    end else begin : g_none
      assign pins_nxt[p] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r <= '0;
    end else if (fire) begin
      pins_r <= pins_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {(OUT_TDATA_W - PIN_W - 1)'(0), applied, pins_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/mcpwm_chk.sv @@
// Port-level checker for the multi-channel PWM generator, bound to the top.
// Depends on mcpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcpwm_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [mcpwm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import mcpwm_pkg::*;

  // A stalled result holds its word
  `AST_CLKD(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // Reset empties the result stage
  `AST_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid)

  // Input only backs up when a result is stuck at the output
  `AST_CLKD(a_backpressure, !in_tready |-> out_tvalid && !out_tready)

  // A fresh result comes from an accepted word that went straight through the input register
  `AST_CLKD(a_latency, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))

  // Pad bits of the result stay zero
  `AST_CLKD(a_pad_zero, out_tvalid |-> out_tdata[OUT_TDATA_W-1:PIN_W+1] == '0)

endmodule

bind multi_channel_pwm_generator mcpwm_chk u_mcpwm_chk (.*);
